/* hdl/srb_pkg.sv */
`default_nettype none

package srb_pkg;

    // Item kind carried in the low bit of the input tuser
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Fixed field widths
    localparam int IDX_W  = 32;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 7;

    // Stream bus widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    // Classified command handed from the front to the back
    typedef struct packed {
        logic              is_read;
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  end_pos;
        logic [BYTE_W-1:0] data;
        logic              has;
        logic              mark;
        logic [CNT_W-1:0]  rc;
    } t_cmd;

    // Command queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

/* hdl/srb_front.sv */
`default_nettype none

module srb_front (
    input  wire logic                            i_enable,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // stream_index[31:0], data_byte[39:32], read_count[46:40], zero pad
    input  wire logic [srb_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // func[0], has_byte[1]
    input  wire logic [srb_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    input  wire logic                            s_axis_tlast,
    input  wire srb_pkg::t_q_status              i_q_status,
    output logic                                 o_push,
    output srb_pkg::t_cmd                        o_cmd
);

    logic w_is_read;
    logic w_has;

    // Take a beat whenever the queue has room and the back is out of its clear pass
    assign s_axis_tready = i_enable && !i_q_status.full;
    assign o_push        = s_axis_tvalid && s_axis_tready;

    // Classify the beat and precompute the end position
    assign w_is_read = (s_axis_tuser[0] == srb_pkg::FUNC_READ);
    assign w_has     = s_axis_tuser[1] && !w_is_read;

    always_comb begin
        o_cmd.is_read = w_is_read;
        o_cmd.idx     = s_axis_tdata[srb_pkg::IDX_W-1:0];
        o_cmd.end_pos = s_axis_tdata[srb_pkg::IDX_W-1:0]
                        + {{(srb_pkg::IDX_W-1){1'b0}}, w_has};
        o_cmd.data    = s_axis_tdata[srb_pkg::IDX_W +: srb_pkg::BYTE_W];
        o_cmd.has     = w_has;
        o_cmd.mark    = s_axis_tlast && !w_is_read;
        o_cmd.rc      = s_axis_tdata[srb_pkg::IDX_W+srb_pkg::BYTE_W +: srb_pkg::CNT_W];
    end

endmodule

`default_nettype wire

/* hdl/srb_queue.sv */
`default_nettype none

module srb_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire srb_pkg::t_cmd      i_cmd,
    input  wire logic               i_pop,
    output srb_pkg::t_cmd           o_cmd,
    output srb_pkg::t_q_status      o_status
);

    localparam int DEPTH = 2;

    srb_pkg::t_cmd r_slot [DEPTH];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic [1:0]    n_count;

    // Store the entry on push
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Track occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    assign o_cmd          = r_slot[r_rd_ptr];
    assign o_status.full  = (r_count == 2'(DEPTH));
    assign o_status.empty = (r_count == 2'd0);

endmodule

`default_nettype wire

/* hdl/srb_back.sv */
`default_nettype none

module srb_back #(
    parameter int CAPACITY = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire srb_pkg::t_cmd                 i_cmd,
    input  wire srb_pkg::t_q_status            i_q_status,
    output logic                               o_pop,
    output logic                               o_clearing,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // out_byte[7:0], stream_done[8], pending_bytes[15:9]
    output logic [srb_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // byte_valid[0]
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int FW = (CW > srb_pkg::CNT_W) ? CW : srb_pkg::CNT_W;
    localparam int DW = srb_pkg::BYTE_W + 1;
    localparam int XW = srb_pkg::IDX_W;

    localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);
    localparam logic [IW:0]   CAP_SUM   = (IW + 1)'(CAPACITY);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_EVAL     = 3'd2;
    localparam logic [2:0] S_PUSH_RD  = 3'd3;
    localparam logic [2:0] S_PUSH_WR  = 3'd4;
    localparam logic [2:0] S_REL_RD   = 3'd5;
    localparam logic [2:0] S_REL_CHK  = 3'd6;

    // Ring of {valid, byte}
    logic [DW-1:0] r_ram [CAPACITY];
    logic [DW-1:0] r_mem_q;

    logic                          w_we;
    logic [IW-1:0]                 w_wa;
    logic [DW-1:0]                 w_wd;
    logic                          w_re;
    logic [IW-1:0]                 w_ra;

    // Control state
    logic [2:0]                    r_state,      n_state;
    logic [IW-1:0]                 r_clr_addr,   n_clr_addr;
    logic [XW-1:0]                 r_next_exp,   n_next_exp;
    logic [CW-1:0]                 r_fill,       n_fill;
    logic                          r_end_known,  n_end_known;
    logic [XW-1:0]                 r_end_pos,    n_end_pos;
    logic [CW-1:0]                 r_pending,    n_pending;
    logic                          r_ended,      n_ended;
    logic [IW-1:0]                 r_head,       n_head;
    logic                          r_hold_valid, n_hold_valid;
    logic                          r_out_valid,  n_out_valid;

    // Payload
    srb_pkg::t_cmd                 r_cmd;
    logic [IW-1:0]                 r_slot;
    logic [srb_pkg::BYTE_W-1:0]    r_hold_byte,  n_hold_byte;
    logic                          r_hold_done,  n_hold_done;
    logic [srb_pkg::CNT_W-1:0]     r_hold_pend,  n_hold_pend;
    logic [srb_pkg::BYTE_W-1:0]    r_out_byte,   n_out_byte;
    logic                          r_out_bv,     n_out_bv;
    logic                          r_out_last,   n_out_last;
    logic                          r_out_done,   n_out_done;
    logic [srb_pkg::CNT_W-1:0]     r_out_pend,   n_out_pend;

    // Datapath helpers
    logic [CW-1:0]                 w_space;
    logic [XW-1:0]                 w_space_x;
    logic [XW-1:0]                 w_dist;
    logic                          w_store;
    logic                          w_end_ok;
    logic [IW:0]                   w_slot_sum;
    logic [IW-1:0]                 w_slot;
    logic [FW-1:0]                 w_fill_x;
    logic [FW-1:0]                 w_rc_x;
    logic [CW-1:0]                 w_fill_rd;
    logic                          w_out_free;
    logic                          w_found;
    logic [IW-1:0]                 w_head_inc;
    logic [XW-1:0]                 w_next_inc;
    logic [CW-1:0]                 w_pend_dec;
    logic                          w_done_after;
    logic                          w_done_now;

    // Window math for a push
    assign w_space   = CAP_CNT - r_fill;
    assign w_space_x = XW'(w_space);
    assign w_dist    = r_cmd.idx - r_next_exp;
    assign w_store   = !r_ended && r_cmd.has && (w_dist < w_space_x)
                       && !(r_end_known && (w_dist >= (r_end_pos - r_next_exp)));
    assign w_end_ok  = r_cmd.mark && !r_end_known && !r_ended
                       && ((r_cmd.end_pos - r_next_exp) <= w_space_x);
    assign w_slot_sum = {1'b0, r_head} + {1'b0, w_dist[IW-1:0]};
    assign w_slot     = (w_slot_sum >= CAP_SUM) ? IW'(w_slot_sum - CAP_SUM)
                                                : w_slot_sum[IW-1:0];

    // Saturating fill release for a read
    assign w_fill_x  = FW'(r_fill);
    assign w_rc_x    = FW'(r_cmd.rc);
    assign w_fill_rd = (w_rc_x >= w_fill_x) ? '0 : CW'(w_fill_x - w_rc_x);

    // Release step helpers
    assign w_out_free   = !r_out_valid || m_axis_tready;
    assign w_found      = r_mem_q[DW-1] && (r_fill < CAP_CNT);
    assign w_head_inc   = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
    assign w_next_inc   = r_next_exp + 1'b1;
    assign w_pend_dec   = (r_pending != '0) ? r_pending - 1'b1 : '0;
    assign w_done_after = r_ended || (r_end_known && (r_end_pos == w_next_inc));
    assign w_done_now   = r_ended || (r_end_known && (r_end_pos == r_next_exp));

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_next_exp   = r_next_exp;
        n_fill       = r_fill;
        n_end_known  = r_end_known;
        n_end_pos    = r_end_pos;
        n_pending    = r_pending;
        n_ended      = r_ended;
        n_head       = r_head;
        n_hold_valid = r_hold_valid;
        n_hold_byte  = r_hold_byte;
        n_hold_done  = r_hold_done;
        n_hold_pend  = r_hold_pend;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_byte   = r_out_byte;
        n_out_bv     = r_out_bv;
        n_out_last   = r_out_last;
        n_out_done   = r_out_done;
        n_out_pend   = r_out_pend;
        o_pop        = 1'b0;
        w_we         = 1'b0;
        w_wa         = r_head;
        w_wd         = '0;
        w_re         = 1'b0;
        w_ra         = r_head;

        unique case (r_state)
            S_CLEAR: begin
                w_we       = 1'b1;
                w_wa       = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_cmd.is_read) begin
                    n_fill  = w_fill_rd;
                    n_state = S_REL_RD;
                end else begin
                    if (w_end_ok) begin
                        n_end_known = 1'b1;
                        n_end_pos   = r_cmd.end_pos;
                    end
                    n_state = w_store ? S_PUSH_RD : S_REL_RD;
                end
            end
            S_PUSH_RD: begin
                w_re    = 1'b1;
                w_ra    = r_slot;
                n_state = S_PUSH_WR;
            end
            S_PUSH_WR: begin
                // Keep a byte already stored at this slot
                if (!r_mem_q[DW-1]) begin
                    w_we      = 1'b1;
                    w_wa      = r_slot;
                    w_wd      = {1'b1, r_cmd.data};
                    n_pending = r_pending + 1'b1;
                end
                n_state = S_REL_RD;
            end
            S_REL_RD: begin
                w_re    = 1'b1;
                n_state = S_REL_CHK;
            end
            S_REL_CHK: begin
                if (w_found) begin
                    if (!r_hold_valid || w_out_free) begin
                        // Send the held byte, hold this one until we know if it is last
                        if (r_hold_valid) begin
                            n_out_valid = 1'b1;
                            n_out_byte  = r_hold_byte;
                            n_out_bv    = 1'b1;
                            n_out_last  = 1'b0;
                            n_out_done  = r_hold_done;
                            n_out_pend  = r_hold_pend;
                        end
                        n_hold_valid = 1'b1;
                        n_hold_byte  = r_mem_q[srb_pkg::BYTE_W-1:0];
                        n_hold_done  = w_done_after;
                        n_hold_pend  = w_pend_dec[srb_pkg::CNT_W-1:0];
                        w_we         = 1'b1;
                        n_head       = w_head_inc;
                        n_next_exp   = w_next_inc;
                        n_pending    = w_pend_dec;
                        n_fill       = r_fill + 1'b1;
                        n_ended      = w_done_after;
                        n_state      = S_REL_RD;
                    end
                end else begin
                    n_ended = w_done_now;
                    if (w_out_free) begin
                        // Close the item: held byte as last, or a status beat
                        n_out_valid = 1'b1;
                        n_out_last  = 1'b1;
                        if (r_hold_valid) begin
                            n_out_byte   = r_hold_byte;
                            n_out_bv     = 1'b1;
                            n_out_done   = r_hold_done;
                            n_out_pend   = r_hold_pend;
                            n_hold_valid = 1'b0;
                        end else begin
                            n_out_byte = '0;
                            n_out_bv   = 1'b0;
                            n_out_done = w_done_now;
                            n_out_pend = r_pending[srb_pkg::CNT_W-1:0];
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Ring write port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_ram[w_wa] <= w_wd;
        end
    end

    // Ring read port, registered
    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_mem_q <= r_ram[w_ra];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_next_exp   <= '0;
            r_fill       <= '0;
            r_end_known  <= 1'b0;
            r_end_pos    <= '0;
            r_pending    <= '0;
            r_ended      <= 1'b0;
            r_head       <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_next_exp   <= n_next_exp;
            r_fill       <= n_fill;
            r_end_known  <= n_end_known;
            r_end_pos    <= n_end_pos;
            r_pending    <= n_pending;
            r_ended      <= n_ended;
            r_head       <= n_head;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_EVAL) begin
            r_slot <= w_slot;
        end
        r_hold_byte <= n_hold_byte;
        r_hold_done <= n_hold_done;
        r_hold_pend <= n_hold_pend;
        r_out_byte  <= n_out_byte;
        r_out_bv    <= n_out_bv;
        r_out_last  <= n_out_last;
        r_out_done  <= n_out_done;
        r_out_pend  <= n_out_pend;
    end

    assign o_clearing    = (r_state == S_CLEAR);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_pend, r_out_done, r_out_byte};
    assign m_axis_tuser  = r_out_bv;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

/* hdl/stream_byte_reassembler_core.sv */
// Flow: with the back end idle an input beat passes the queue and is popped and evaluated; a push
// that stores a byte then reads and writes its ring slot; the ring head is read and checked, and a
// status beat leaves if nothing is released. A released byte is held for one more ring check, and
// each further byte takes a ring read, check and clear. The ring walk in the back end handles one
// item at a time; a 2-entry queue lets the input run ahead.
// Reset: synchronous, active low; the ring is then cleared slot by slot, no beat taken.
`default_nettype none

module stream_byte_reassembler_core #(
    parameter int CAPACITY = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // stream_index[31:0], data_byte[39:32], read_count[46:40], zero pad [47]
    input  wire logic [srb_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // func[0], has_byte[1]
    input  wire logic [srb_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    // end_mark
    input  wire logic                            s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // out_byte[7:0], stream_done[8], pending_bytes[15:9]
    output logic [srb_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    // byte_valid[0]
    output logic                                 m_axis_tuser,
    // last_result
    output logic                                 m_axis_tlast
);

    logic                  w_clearing;
    logic                  w_q_push;
    logic                  w_q_pop;
    srb_pkg::t_cmd         w_front_cmd;
    srb_pkg::t_cmd         w_q_cmd;
    srb_pkg::t_q_status    w_q_status;

    // Accept and classify beats
    srb_front u_front (
        .i_enable      (!w_clearing),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .i_q_status    (w_q_status),
        .o_push        (w_q_push),
        .o_cmd         (w_front_cmd)
    );

    // Decouple front and back
    srb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_q_push),
        .i_cmd    (w_front_cmd),
        .i_pop    (w_q_pop),
        .o_cmd    (w_q_cmd),
        .o_status (w_q_status)
    );

    // Store bytes and release them in order
    srb_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_q_cmd),
        .i_q_status    (w_q_status),
        .o_pop         (w_q_pop),
        .o_clearing    (w_clearing),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    // No beat is taken while the ring is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> !w_clearing)
        else $error("input beat accepted during clear pass");

    // The front never writes a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_status.full)
        else $error("queue overflow");

    // The back never pops an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_status.empty)
        else $error("queue underflow");

    // A pop during clearing would mean the back left its clear pass early
    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !w_q_pop)
        else $error("command popped during clear pass");
`endif

endmodule

`default_nettype wire

/* sim/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W       = srb_pkg::IDX_W;
    localparam int BYTE_W      = srb_pkg::BYTE_W;
    localparam int CNT_W       = srb_pkg::CNT_W;
    localparam int S_TDATA_W   = srb_pkg::S_TDATA_W;
    localparam int S_TUSER_W   = srb_pkg::S_TUSER_W;
    localparam int M_TDATA_W   = srb_pkg::M_TDATA_W;

    localparam int CAPACITY    = 64;
    localparam int HALF_CLK    = 6;
    localparam int RESET_CYC   = 11;
    localparam int HOLD_AT     = 40;
    localparam int HOLD_CYC    = 300;
    localparam int DRAIN_CYC   = 40;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_CMDS = 148;

    typedef struct {
        logic              func;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
        logic              has;
        logic              mark;
        logic [CNT_W-1:0]  rc;
    } t_stream_cmd;

    typedef struct {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              last_result;
        logic              stream_done;
        logic [CNT_W-1:0]  pending_bytes;
    } t_release;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // stream_index[31:0], data_byte[39:32], read_count[46:40], zero pad [47]
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    // func[0], has_byte[1]
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    // end_mark
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // out_byte[7:0], stream_done[8], pending_bytes[15:9]
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // byte_valid[0]
    logic                 m_axis_tuser;
    // last_result
    logic                 m_axis_tlast;

    stream_byte_reassembler_core #(.CAPACITY(CAPACITY)) uut (.*);

    // Reassembly state mirrored by the predictor
    logic [BYTE_W-1:0] ring_data [CAPACITY];
    logic              ring_valid [CAPACITY] = '{default: 1'b0};
    logic [IDX_W-1:0]  next_idx = '0;
    logic [IDX_W-1:0]  end_idx = '0;
    logic [31:0]       out_fill = '0;
    logic              end_known = 1'b0;
    logic              stream_ended = 1'b0;
    int                ring_head = 0;
    int                stored_count = 0;

    t_stream_cmd stream_cmds[$];
    t_stream_cmd cmd_on_bus;
    t_release    expected_releases[$];
    t_release    seen;
    t_release    want;
    int          total_cmds;
    int          cmds_taken = 0;
    int          releases_seen = 0;
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int          send_gap = 0;
    int          recv_stall = 0;
    logic        send_burst = 1'b0;
    logic        recv_burst = 1'b0;
    logic        hold_done = 1'b0;
    logic        send_valid;
    logic        recv_ready;

    // Stimulus generator's view of the stream position and the output fill
    logic [IDX_W-1:0] gen_base;
    int               gen_fill;

    // Store one pushed byte or read, then release every in-order byte it unblocks
    task automatic reassemble_item(input t_stream_cmd it);
        logic [31:0] space;
        logic [31:0] offset;
        logic [31:0] stop_pos;
        int          slot;
        int          n;
        t_release    rel;
        n = 0;
        if (it.func == srb_pkg::FUNC_READ) begin
            out_fill = (32'(it.rc) >= out_fill) ? 32'd0 : out_fill - 32'(it.rc);
        end else if (!stream_ended) begin
            space  = 32'(CAPACITY) - out_fill;
            offset = it.idx - next_idx;
            // drop bytes outside the window or at and after a known end
            if (it.has && offset < space && !(end_known && offset >= end_idx - next_idx)) begin
                slot = (ring_head + int'(offset)) % CAPACITY;
                if (!ring_valid[slot]) begin
                    ring_valid[slot] = 1'b1;
                    ring_data[slot]  = it.data;
                    stored_count++;
                end
            end
            // record the first end mark that fits the window
            if (it.mark && !end_known) begin
                stop_pos = it.idx + 32'(it.has);
                if (stop_pos - next_idx <= space) begin
                    end_known = 1'b1;
                    end_idx   = stop_pos;
                end
            end
        end
        while (ring_valid[ring_head] && out_fill < 32'(CAPACITY)) begin
            rel.out_byte = ring_data[ring_head];
            ring_valid[ring_head] = 1'b0;
            ring_head = (ring_head + 1) % CAPACITY;
            next_idx++;
            if (stored_count > 0) stored_count--;
            out_fill++;
            if (end_known && end_idx == next_idx) stream_ended = 1'b1;
            rel.byte_valid    = 1'b1;
            rel.last_result   = 1'b0;
            rel.stream_done   = stream_ended;
            rel.pending_bytes = CNT_W'(stored_count);
            expected_releases = {expected_releases, rel};
            n++;
        end
        if (end_known && end_idx == next_idx) stream_ended = 1'b1;
        // nothing released: one status beat
        if (n == 0) begin
            rel.out_byte      = '0;
            rel.byte_valid    = 1'b0;
            rel.last_result   = 1'b0;
            rel.stream_done   = stream_ended;
            rel.pending_bytes = CNT_W'(stored_count);
            expected_releases = {expected_releases, rel};
        end
        expected_releases[expected_releases.size()-1].last_result = 1'b1;
    endtask

    function automatic void add_push(logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] data,
                                     logic has, logic mark);
        t_stream_cmd c;
        c.func = srb_pkg::FUNC_PUSH;
        c.idx  = idx;
        c.data = data;
        c.has  = has;
        c.mark = mark;
        c.rc   = CNT_W'($urandom_range(0, 64));
        stream_cmds = {stream_cmds, c};
    endfunction

    function automatic void add_read(int rc);
        t_stream_cmd c;
        c.func = srb_pkg::FUNC_READ;
        c.idx  = $urandom;
        c.data = BYTE_W'($urandom);
        c.has  = 1'($urandom);
        c.mark = 1'($urandom);
        c.rc   = CNT_W'(rc);
        stream_cmds = {stream_cmds, c};
        gen_fill = (rc >= gen_fill) ? 0 : gen_fill - rc;
    endfunction

    // Random index well away from the window, so its byte and end mark are both ignored
    function automatic logic [IDX_W-1:0] far_index();
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] gap;
        idx = $urandom;
        gap = idx - gen_base;
        if (gap < 32'd256 || gap > 32'hFFFF_FF00) idx[31] = ~idx[31];
        return idx;
    endfunction

    // Push the segment [gen_base, gen_base+len) shuffled (or reversed) with some repeats
    task automatic push_chunk(int len, logic reversed);
        int order[$];
        int j;
        int pick;
        int tmp;
        for (j = 0; j < len; j++) begin
            order = {order, (reversed ? len - 1 - j : j)};
        end
        if (!reversed) begin
            for (j = len - 1; j > 0; j--) begin
                pick = $urandom_range(0, j);
                tmp = order[j];
                order[j] = order[pick];
                order[pick] = tmp;
            end
        end
        for (j = 0; j < len; j++) begin
            add_push(gen_base + IDX_W'(order[j]), BYTE_W'($urandom), 1'b1, 1'b0);
            if ($urandom_range(0, 5) == 0) begin
                pick = $urandom_range(0, j);
                add_push(gen_base + IDX_W'(order[pick]), BYTE_W'($urandom), 1'b1, 1'b0);
            end
        end
        // bytes past the free output space are dropped and sent again later
        tmp = (CAPACITY - gen_fill < len) ? CAPACITY - gen_fill : len;
        gen_base += IDX_W'(tmp);
        gen_fill += tmp;
    endtask

    task automatic build_stimulus();
        int          directed_count;
        int          roll;
        int          finish_len;
        logic        burst_done;
        logic [31:0] stop_at;

        // directed: overlap, stale, wrapped and out-of-window bytes, ignored end marks
        gen_base = '0;
        gen_fill = 0;
        add_read(0);
        add_push(32'd1, 8'hFF, 1'b1, 1'b0);
        add_push(32'd1, 8'h00, 1'b1, 1'b0);
        add_push(32'd0, 8'h00, 1'b1, 1'b0);
        add_push(32'd0, 8'h55, 1'b1, 1'b0);
        add_push(32'hFFFF_FFFF, 8'hAA, 1'b1, 1'b0);
        add_push(32'd66, 8'h11, 1'b1, 1'b0);
        add_push(32'd64, 8'h22, 1'b1, 1'b0);
        add_push(32'd5, 8'h33, 1'b0, 1'b0);
        add_push(32'h8000_0000, 8'h44, 1'b0, 1'b1);
        add_push(32'hFFFF_FFFF, 8'h66, 1'b1, 1'b1);
        gen_fill = 2;
        add_read(64);
        gen_base = 32'd2;
        directed_count = stream_cmds.size();

        // random: mostly in-window segments, some reads, some noise, one full-window burst
        burst_done = 1'b0;
        while (stream_cmds.size() < directed_count + RANDOM_CMDS) begin
            roll = $urandom_range(0, 19);
            if (!burst_done && stream_cmds.size() > directed_count + 60) begin
                add_read(64);
                push_chunk(CAPACITY, 1'b1);
                burst_done = 1'b1;
            end else if (roll < 3) begin
                case ($urandom_range(0, 3))
                    0: add_push(far_index(), BYTE_W'($urandom), 1'($urandom), 1'($urandom));
                    1: add_push(gen_base + 32'd65 + 32'($urandom_range(0, 300)),
                                BYTE_W'($urandom), 1'($urandom), 1'($urandom));
                    2: begin
                        if (gen_base >= 32'd2) begin
                            add_push(gen_base - 32'd2 - 32'($urandom_range(0, gen_base - 2)),
                                     BYTE_W'($urandom), 1'($urandom), 1'($urandom));
                        end else begin
                            add_push(far_index(), BYTE_W'($urandom), 1'b1, 1'b0);
                        end
                    end
                    default: add_push(far_index(), BYTE_W'($urandom), 1'b0, 1'b0);
                endcase
            end else if (roll < 8) begin
                add_read(($urandom_range(0, 3) == 0) ? $urandom_range(0, 64)
                                                      : $urandom_range(0, 12));
            end else begin
                push_chunk($urandom_range(1, 10), 1'b0);
            end
        end

        // close the stream: end mark first, then bytes at and past it, then the gap
        add_read(64);
        finish_len = $urandom_range(3, 10);
        stop_at = gen_base + 32'(finish_len);
        add_push(stop_at - 32'd1, BYTE_W'($urandom), 1'b1, 1'b1);
        add_push(stop_at, BYTE_W'($urandom), 1'b1, 1'b0);
        add_push(stop_at + 32'd2, BYTE_W'($urandom), 1'b1, 1'b1);
        add_push(stop_at + 32'd5, BYTE_W'($urandom), 1'b0, 1'b1);
        push_chunk(finish_len, 1'b0);

        // after the stream is done pushes are ignored
        add_push(gen_base, BYTE_W'($urandom), 1'b1, 1'b1);
        add_read($urandom_range(0, 64));
        add_push(gen_base, BYTE_W'($urandom), 1'b0, 1'b1);
    endtask

    function automatic int draw_gap(inout logic burst);
        if ($urandom_range(0, 19) == 0) burst = !burst;
        return burst ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic void check_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            mismatch_count++;
        end
    endfunction

    // Clock
    initial begin
        forever #HALF_CLK i_clk = ~i_clk;
    end

    // Offer queued commands, one beat each, with a random gap after each accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            s_axis_tlast  <= 1'b0;
            send_gap = 0;
        end else begin
            send_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                reassemble_item(cmd_on_bus);
                cmds_taken++;
                send_valid = 1'b0;
                send_gap = draw_gap(send_burst);
            end
            if (!send_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (stream_cmds.size() > 0) begin
                    cmd_on_bus = stream_cmds.pop_front();
                    s_axis_tdata <= {1'b0, cmd_on_bus.rc, cmd_on_bus.data, cmd_on_bus.idx};
                    s_axis_tuser <= {cmd_on_bus.has, cmd_on_bus.func};
                    s_axis_tlast <= cmd_on_bus.mark;
                    send_valid = 1'b1;
                end
            end
            s_axis_tvalid <= send_valid;
        end
    end

    // Check each result beat against the oldest expectation, then stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen.out_byte      = m_axis_tdata[7:0];
                seen.stream_done   = m_axis_tdata[8];
                seen.pending_bytes = m_axis_tdata[15:9];
                seen.byte_valid    = m_axis_tuser;
                seen.last_result   = m_axis_tlast;
                releases_seen++;
                if (expected_releases.size() == 0) begin
                    $error("result beat with nothing expected: out_byte %0d byte_valid %0d",
                           seen.out_byte, seen.byte_valid);
                    mismatch_count++;
                end else begin
                    want = expected_releases.pop_front();
                    check_field("out_byte", want.out_byte, seen.out_byte);
                    check_field("byte_valid", 8'(want.byte_valid), 8'(seen.byte_valid));
                    check_field("last_result", 8'(want.last_result), 8'(seen.last_result));
                    check_field("stream_done", 8'(want.stream_done), 8'(seen.stream_done));
                    check_field("pending_bytes", 8'(want.pending_bytes),
                                8'(seen.pending_bytes));
                end
                recv_stall = draw_gap(recv_burst);
                // hold off once long enough to back up the input side
                if (!hold_done && releases_seen == HOLD_AT) begin
                    recv_stall = HOLD_CYC;
                    hold_done = 1'b1;
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                recv_ready = 1'b0;
            end else begin
                recv_ready = 1'b1;
            end
            m_axis_tready <= recv_ready;
        end
    end

    // Abort when no beat moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $error("no beat for %0d cycles, %0d results outstanding",
                   quiet_cycles, expected_releases.size());
            $display("stream_byte_reassembler_core verification failed");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    initial begin
        build_stimulus();
        total_cmds = stream_cmds.size();
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (cmds_taken < total_cmds) @(posedge i_clk);
        while (expected_releases.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("stream_byte_reassembler_core verification clean");
        end else begin
            $display("stream_byte_reassembler_core verification failed");
        end
        $finish;
    end

endmodule
